### design/b32_pkg.sv
// ----------------------------------------------------------------------------
// b32_pkg
// Types, codes and character helpers shared by the base32 codec modules.
// ----------------------------------------------------------------------------
package b32_pkg;

	localparam int GROUP_W = 40;

	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam logic [7:0] CHAR_A   = 8'h41;
	localparam logic [7:0] CHAR_2   = 8'h32;
	localparam logic [4:0] DIGIT_26 = 5'd26;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_ENC = 2'd0;
	localparam kind_t KIND_DEC = 2'd1;
	localparam kind_t KIND_ERR = 2'd2;

	// one queued job: the results of one input transfer
	typedef struct packed {
		kind_t              kind;
		logic [GROUP_W-1:0] bits;
		logic [3:0]         count;
		logic [3:0]         used;
		logic               eom;
	} job_t;

	typedef struct packed {
		logic [7:0] data;
		logic       err;
		logic       last;
		logic       done;
	} result_t;

	function automatic logic [7:0] b32_char(input logic [4:0] idx);
		logic [7:0] c;
		if (idx < DIGIT_26) begin
			c = CHAR_A + {3'b000, idx};
		end else begin
			c = CHAR_2 + {3'b000, idx - DIGIT_26};
		end
		return c;
	endfunction

	// {valid, digit}
	function automatic logic [5:0] b32_value(input logic [7:0] c);
		logic [5:0] v;
		v = '0;
		if (c >= CHAR_A && c <= 8'h5A) begin
			v = {1'b1, 5'(c - CHAR_A)};
		end else if (c >= CHAR_2 && c <= 8'h37) begin
			v = {1'b1, 5'(c - CHAR_2) + DIGIT_26};
		end
		return v;
	endfunction

endpackage

### design/b32_front.sv
// ----------------------------------------------------------------------------
// b32_front
// Accepts input transfers, gathers groups and turns each finished group or
// error into a job for the output side.
// ----------------------------------------------------------------------------
module b32_front import b32_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // data_byte
	input  logic       s_axis_tlast,  // end_of_message
	input  logic       q_full,
	output logic       push,
	output job_t       push_job
);

	logic               mode_q;
	logic [GROUP_W-1:0] bits_q;
	logic [3:0]         cnt_q;
	logic [3:0]         pad_q;
	logic               hold_q;

	logic [GROUP_W-1:0] bits_d;
	logic [3:0]         cnt_d;
	logic [3:0]         pad_d;
	logic               hold_d;
	logic               job_vld;
	job_t               job;

	logic               accept;
	logic [3:0]         cnt_inc;
	logic [GROUP_W-1:0] enc_bits;
	logic [GROUP_W-1:0] dec_bits;
	logic [3:0]         pad_inc;
	logic [5:0]         val;
	logic               is_pad;

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign push          = accept && job_vld;
	assign push_job      = job;

	assign cnt_inc  = cnt_q + 4'd1;
	assign enc_bits = {bits_q[GROUP_W-9:0], s_axis_tdata};
	assign val      = b32_value(s_axis_tdata);
	assign is_pad   = (s_axis_tdata == PAD_CHAR);
	assign dec_bits = is_pad ? bits_q : {bits_q[GROUP_W-6:0], val[4:0]};
	assign pad_inc  = is_pad ? pad_q + 4'd1 : pad_q;

	always_comb begin
		bits_d  = bits_q;
		cnt_d   = cnt_q;
		pad_d   = pad_q;
		hold_d  = hold_q;
		job_vld = 1'b0;
		job     = '0;
		job.eom = s_axis_tlast;
		if (!mode_q) begin
			job.kind  = KIND_ENC;
			job.count = 4'd8;
			case (cnt_inc)
				4'd1: begin
					job.bits = enc_bits << 32;
					job.used = 4'd2;
				end
				4'd2: begin
					job.bits = enc_bits << 24;
					job.used = 4'd4;
				end
				4'd3: begin
					job.bits = enc_bits << 16;
					job.used = 4'd5;
				end
				4'd4: begin
					job.bits = enc_bits << 8;
					job.used = 4'd7;
				end
				default: begin
					job.bits = enc_bits;
					job.used = 4'd8;
				end
			endcase
			if (cnt_inc >= 4'd5 || s_axis_tlast) begin
				job_vld = 1'b1;
				bits_d  = '0;
				cnt_d   = '0;
			end else begin
				bits_d = enc_bits;
				cnt_d  = cnt_inc;
			end
		end else if (hold_q) begin
			if (s_axis_tlast) begin
				hold_d = 1'b0;
				bits_d = '0;
				cnt_d  = '0;
				pad_d  = '0;
			end
		end else if (!is_pad && !val[5]) begin
			job_vld   = 1'b1;
			job.kind  = KIND_ERR;
			job.count = 4'd1;
			bits_d    = '0;
			cnt_d     = '0;
			pad_d     = '0;
			hold_d    = !s_axis_tlast;
		end else begin
			job.kind = KIND_DEC;
			job.bits = dec_bits << (6'(pad_inc) * 6'd5);
			case (pad_inc)
				4'd0:       job.count = 4'd5;
				4'd1:       job.count = 4'd4;
				4'd2, 4'd3: job.count = 4'd3;
				4'd4:       job.count = 4'd2;
				4'd5, 4'd6: job.count = 4'd1;
				default:    job.count = 4'd0;
			endcase
			bits_d = dec_bits;
			cnt_d  = cnt_inc;
			pad_d  = pad_inc;
			if (cnt_inc == 4'd8) begin
				job_vld = (job.count != 4'd0);
				bits_d  = '0;
				cnt_d   = '0;
				pad_d   = '0;
			end
			if (s_axis_tlast) begin
				bits_d = '0;
				cnt_d  = '0;
				pad_d  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			bits_q <= '0;
			cnt_q  <= '0;
			pad_q  <= '0;
			hold_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
			bits_q <= '0;
			cnt_q  <= '0;
			pad_q  <= '0;
			hold_q <= 1'b0;
		end else if (accept) begin
			bits_q <= bits_d;
			cnt_q  <= cnt_d;
			pad_q  <= pad_d;
			hold_q <= hold_d;
		end
	end

endmodule

### design/b32_queue.sv
// ----------------------------------------------------------------------------
// b32_queue
// Small job queue between the input side and the output side.
// ----------------------------------------------------------------------------
module b32_queue import b32_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic head_vld,
	output job_t head_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign head_vld = (cnt_q != '0);
	assign head_job = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### design/b32_back.sv
// ----------------------------------------------------------------------------
// b32_back
// Steps head job results into the output register one per cycle unless stalled.
// ----------------------------------------------------------------------------
module b32_back import b32_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_vld,
	input  job_t       head_job,
	output logic       pop,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // out_byte
	output logic [1:0] m_axis_tuser,  // error, message_done
	output logic       m_axis_tlast   // last_of_run
);

	logic [2:0]         idx_q;
	logic               out_vld_q;
	result_t            out_q;
	result_t            res;
	logic               load;
	logic               is_last;
	logic [GROUP_W-1:0] char_win;
	logic [GROUP_W-1:0] byte_win;

	assign load     = head_vld && (!out_vld_q || m_axis_tready);
	assign is_last  = ({1'b0, idx_q} == head_job.count - 4'd1);
	assign pop      = load && is_last;
	assign char_win = head_job.bits << (6'(idx_q) * 6'd5);
	assign byte_win = head_job.bits << {idx_q, 3'b000};

	always_comb begin
		res      = '0;
		res.last = is_last;
		res.done = is_last && head_job.eom;
		case (head_job.kind)
			KIND_ENC: begin
				res.data = ({1'b0, idx_q} < head_job.used) ?
					b32_char(char_win[GROUP_W-1 -: 5]) : PAD_CHAR;
			end
			KIND_DEC: begin
				res.data = byte_win[GROUP_W-1 -: 8];
			end
			KIND_ERR: begin
				res.err = 1'b1;
			end
			default: begin
				res.data = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= is_last ? '0 : idx_q + 3'd1;
			end
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q.data;
	assign m_axis_tuser  = {out_q.done, out_q.err};
	assign m_axis_tlast  = out_q.last;

endmodule

### design/base32_codec.sv
// ----------------------------------------------------------------------------
// base32_codec
// Streaming base32 encoder and decoder, standard alphabet, one byte per
// transfer.
// ----------------------------------------------------------------------------
//   channel   dir   payload
//   s_axis    in    tdata = data_byte, tlast = end_of_message
//   m_axis    out   tdata = out_byte, tuser = {message_done, error},
//                   tlast = last_of_run
//   cfg       in    cfg_we / cfg_wdata = mode (0 encode, 1 decode)
//
// Input side takes one transfer per cycle while the job queue has room.
// Output gives one result per cycle while a job waits and m_axis is ready:
// encode gives 8 characters per group of up to 5 bytes, decode up to 5 bytes.
// The job queue of QDEPTH entries lets either side stall on its own.
// Reset is immediate, no clearing pass; a mode write clears the group state.
// ----------------------------------------------------------------------------
module base32_codec import b32_pkg::*; #(
	parameter int QDEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
	input  logic       s_axis_tlast,  // end_of_message
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic [1:0] m_axis_tuser,  // [0] error, [1] message_done
	output logic       m_axis_tlast   // last_of_run
);

	logic q_full;
	logic push;
	logic pop;
	logic head_vld;
	job_t push_job;
	job_t head_job;

	b32_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (q_full),
		.push          (push),
		.push_job      (push_job)
	);

	b32_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (q_full),
		.head_vld (head_vld),
		.head_job (head_job)
	);

	b32_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_vld      (head_vld),
		.head_job      (head_job),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

### design/b32_checker.sv
// ----------------------------------------------------------------------------
// b32_checker
// Port-level checks on the base32 codec result stream.
// ----------------------------------------------------------------------------
module b32_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic [1:0] m_axis_tuser,
	input logic       m_axis_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("result changed while stalled");

	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 8'h00))
		else $error("error result not a single zero transfer");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
		else $error("message end without last of run");

endmodule

bind base32_codec b32_checker u_chk (.*);

### tb/sv/tb_base32_codec.sv
// ----------------------------------------------------------------------------
// tb_base32_codec
// Self-checking bench for the streaming base32 codec. A directed table runs
// known encode and decode vectors, invalid characters and dropped partial
// groups. Random messages in both modes follow, with random stalls on both
// streams. Each result is checked against a hand-typed sequence (pinned rows) or an in-bench codec model.
// ----------------------------------------------------------------------------
module tb_base32_codec;
	import b32_pkg::*;

	typedef enum logic {MODE_ENC = 1'b0, MODE_DEC = 1'b1} codec_mode_e;

	// one stimulus row; pin marks a result sequence typed in by hand
	typedef struct packed {
		codec_mode_e mode;
		logic [7:0]  data;
		logic        eom;
		logic        pin;
		logic        err;
		logic [3:0]  n;
		logic [63:0] txt;
	} vec_row_t;

	localparam logic [255:0] B32_ALPHA = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
	localparam int HOLD_CYCLES = 80;
	localparam int SETTLE_CYCLES = 20;
	localparam int N_DIR = 21;

	localparam vec_row_t DIR_TAB [N_DIR] = '{
		'{MODE_ENC, "f",   1'b1, 1'b1, 1'b0, 4'd8, "MY======"},
		'{MODE_ENC, 8'hFF, 1'b0, 1'b1, 1'b0, 4'd0, 64'd0},
		'{MODE_ENC, 8'hFF, 1'b0, 1'b1, 1'b0, 4'd0, 64'd0},
		'{MODE_ENC, 8'hFF, 1'b0, 1'b1, 1'b0, 4'd0, 64'd0},
		'{MODE_ENC, 8'hFF, 1'b0, 1'b1, 1'b0, 4'd0, 64'd0},
		'{MODE_ENC, 8'hFF, 1'b0, 1'b1, 1'b0, 4'd8, "77777777"},
		'{MODE_ENC, 8'h00, 1'b1, 1'b1, 1'b0, 4'd8, "AA======"},
		'{MODE_ENC, "f",   1'b0, 1'b1, 1'b0, 4'd0, 64'd0},
		'{MODE_ENC, "o",   1'b1, 1'b1, 1'b0, 4'd8, "MZXQ===="},
		'{MODE_DEC, "M",   1'b0, 1'b1, 1'b0, 4'd0, 64'd0},
		'{MODE_DEC, "Y",   1'b0, 1'b1, 1'b0, 4'd0, 64'd0},
		'{MODE_DEC, "=",   1'b0, 1'b0, 1'b0, 4'd0, 64'd0},
		'{MODE_DEC, "=",   1'b0, 1'b0, 1'b0, 4'd0, 64'd0},
		'{MODE_DEC, "=",   1'b0, 1'b0, 1'b0, 4'd0, 64'd0},
		'{MODE_DEC, "=",   1'b0, 1'b0, 1'b0, 4'd0, 64'd0},
		'{MODE_DEC, "=",   1'b0, 1'b0, 1'b0, 4'd0, 64'd0},
		'{MODE_DEC, "=",   1'b1, 1'b1, 1'b0, 4'd1, "f"},
		'{MODE_DEC, "a",   1'b0, 1'b1, 1'b1, 4'd1, 64'd0},
		'{MODE_DEC, "A",   1'b1, 1'b1, 1'b0, 4'd0, 64'd0},
		'{MODE_DEC, 8'hFF, 1'b1, 1'b1, 1'b1, 4'd1, 64'd0},
		'{MODE_DEC, "B",   1'b1, 1'b1, 1'b0, 4'd0, 64'd0}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;  // [7:0] data_byte
	logic       s_axis_tlast = 1'b0;   // end_of_message
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;          // [7:0] out_byte
	logic [1:0] m_axis_tuser;          // [0] error, [1] message_done
	logic       m_axis_tlast;          // last_of_run

	vec_row_t pin_row = '0;

	// codec model state
	codec_mode_e  cur_mode = MODE_ENC;
	logic [39:0]  gbits = '0;
	logic [3:0]   gcnt = '0;
	logic [3:0]   pcnt = '0;
	logic         ehold = 1'b0;

	result_t      fresh_q[$];
	result_t      exp_q[$];
	vec_row_t     stim_q[$];

	codec_mode_e  tb_mode = MODE_ENC;
	bit           no_gap = 1'b0;
	bit           hold_req = 1'b0;
	bit           hold_on = 1'b0;
	int           bad_cnt = 0;
	int           n_enc = 0;
	int           n_dec = 0;
	int           n_res = 0;
	int           n_err_res = 0;
	int           n_cfg = 0;

	base32_codec dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3000000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [7:0] alpha_char(input int idx);
		return B32_ALPHA[8*(31-idx) +: 8];
	endfunction

	task automatic clear_group();
		gbits = '0;
		gcnt = '0;
		pcnt = '0;
	endtask

	// advance the codec model by one byte, leave its results in fresh_q
	task automatic codec_step(input logic [7:0] c, input logic eom);
		int len, used, pad, nbytes, shift, dig, i;
		logic [39:0] v;
		result_t r;
		bit taken;
		fresh_q.delete();
		r = '0;
		if (cur_mode == MODE_ENC) begin
			gbits = {gbits[31:0], c};
			gcnt = gcnt + 4'd1;
			if (gcnt >= 4'd5 || eom) begin
				len = (gcnt > 4'd5) ? 5 : int'(gcnt);
				v = gbits << ((5 - len) * 8);
				used = (len * 8 + 4) / 5;
				for (i = 0; i < 8; i++) begin
					r.data = (i < used) ? alpha_char(int'(v[35-5*i +: 5])) : PAD_CHAR;
					fresh_q.push_back(r);
				end
				clear_group();
			end
		end else if (ehold) begin
			if (eom) begin
				ehold = 1'b0;
				clear_group();
			end
		end else begin
			taken = 1'b1;
			if (c == PAD_CHAR) begin
				pcnt = pcnt + 4'd1;
			end else begin
				dig = -1;
				for (i = 0; i < 32; i++) begin
					if (alpha_char(i) == c) dig = i;
				end
				if (dig < 0) begin
					r.err = 1'b1;
					fresh_q.push_back(r);
					clear_group();
					ehold = !eom;
					taken = 1'b0;
				end else begin
					gbits = {gbits[34:0], 5'(dig)};
				end
			end
			if (taken) begin
				gcnt = gcnt + 4'd1;
				if (gcnt >= 4'd8) begin
					pad = (pcnt > 4'd8) ? 8 : int'(pcnt);
					nbytes = (40 - pad * 5) / 8;
					shift = (8 - pad) * 5 - nbytes * 8;
					for (i = 0; i < nbytes; i++) begin
						v = gbits >> (shift + (nbytes - 1 - i) * 8);
						r.data = v[7:0];
						fresh_q.push_back(r);
					end
					clear_group();
				end
				if (eom) clear_group();
			end
		end
		if (fresh_q.size() > 0) begin
			fresh_q[$].last = 1'b1;
			fresh_q[$].done = eom;
		end
	endtask

	task automatic note_bad(input string what);
		bad_cnt++;
		if (bad_cnt <= 10) $display("mismatch @%0t: %s", $realtime, what);
	endtask

	// check results, track mode writes, predict each input transfer
	always @(posedge clk) begin
		result_t got, want;
		int i;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.data = m_axis_tdata;
				got.err  = m_axis_tuser[0];
				got.last = m_axis_tlast;
				got.done = m_axis_tuser[1];
				n_res++;
				if (got.err) n_err_res++;
				if (exp_q.size() == 0) begin
					note_bad($sformatf("unexpected result data=%02h err=%0b last=%0b done=%0b",
						got.data, got.err, got.last, got.done));
				end else begin
					want = exp_q.pop_front();
					if (got.data !== want.data || got.err !== want.err ||
					    got.last !== want.last || got.done !== want.done) begin
						note_bad($sformatf(
							"exp data=%02h err=%0b last=%0b done=%0b, got data=%02h err=%0b last=%0b done=%0b",
							want.data, want.err, want.last, want.done,
							got.data, got.err, got.last, got.done));
					end
				end
			end
			if (cfg_we) begin
				cur_mode = codec_mode_e'(cfg_wdata);
				ehold = 1'b0;
				clear_group();
			end
			if (s_axis_tvalid && s_axis_tready) begin
				codec_step(s_axis_tdata, s_axis_tlast);
				if (pin_row.pin) begin
					for (i = 0; i < int'(pin_row.n); i++) begin
						want.data = pin_row.txt[8*(int'(pin_row.n)-1-i) +: 8];
						want.err  = pin_row.err;
						want.last = (i == int'(pin_row.n) - 1);
						want.done = want.last && pin_row.eom;
						exp_q.push_back(want);
					end
				end else begin
					foreach (fresh_q[i]) exp_q.push_back(fresh_q[i]);
				end
			end
		end
	end

	// sink side: random ready pattern plus one long hold-off
	initial begin
		bit hold_done;
		int len;
		hold_done = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_on = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_on = 1'b0;
			end else begin
				len = $urandom_range(0, 99);
				if (len < 50) begin
					m_axis_tready <= 1'b1;
					repeat ($urandom_range(1, 12) - 1) @(posedge clk);
				end else if (len < 58) begin
					m_axis_tready <= 1'b1;
					repeat (39) @(posedge clk);
				end else begin
					m_axis_tready <= 1'b0;
					if ($urandom_range(0, 99) < 85)
						repeat ($urandom_range(1, 3) - 1) @(posedge clk);
					else
						repeat ($urandom_range(10, 30) - 1) @(posedge clk);
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gap || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 24);
	endfunction

	task automatic send_item(input vec_row_t row);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= row.data;
		s_axis_tlast  <= row.eom;
		pin_row       <= row;
		do @(posedge clk); while (!s_axis_tready);
		if (tb_mode == MODE_ENC) n_enc++; else n_dec++;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drop valid, wait for every expected result, let the block settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (exp_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input codec_mode_e m);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
		tb_mode = m;
		n_cfg++;
	endtask

	task automatic push_enc_msg();
		vec_row_t r;
		int n;
		r = '0;
		n = $urandom_range(1, 12);
		repeat (n) begin
			r.data = 8'($urandom_range(0, 255));
			stim_q.push_back(r);
		end
		if ($urandom_range(0, 5) != 0) stim_q[$].eom = 1'b1;
	endtask

	// mostly well-formed groups, some stray pads, noise and truncation
	task automatic push_dec_msg();
		vec_row_t r;
		int ng, g, p, k, pad;
		r = '0;
		ng = $urandom_range(1, 3);
		for (g = 0; g < ng; g++) begin
			k = $urandom_range(0, 9);
			pad = 0;
			if (k == 8) begin
				pad = $urandom_range(7, 8);
			end else if (g == ng - 1) begin
				case ($urandom_range(0, 4))
					0: pad = 0;
					1: pad = 1;
					2: pad = 3;
					3: pad = 4;
					default: pad = 6;
				endcase
			end
			for (p = 0; p < 8; p++) begin
				if (p >= 8 - pad || (k == 9 && $urandom_range(0, 3) == 0))
					r.data = PAD_CHAR;
				else
					r.data = alpha_char($urandom_range(0, 31));
				if ($urandom_range(0, 39) == 0) begin
					if ($urandom_range(0, 1) == 0)
						r.data = 8'($urandom_range(0, 255));
					else
						r.data = 8'($urandom_range(8'h61, 8'h7A));
				end
				stim_q.push_back(r);
			end
		end
		if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 7)) void'(stim_q.pop_back());
		if ($urandom_range(0, 5) != 0) stim_q[$].eom = 1'b1;
	endtask

	initial begin
		int i, ph;
		codec_mode_e m;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_DIR; i++) begin
			if (DIR_TAB[i].mode != tb_mode) write_mode(DIR_TAB[i].mode);
			send_item(DIR_TAB[i]);
		end

		for (ph = 0; ph < 5; ph++) begin
			m = (ph == 4) ? codec_mode_e'($urandom_range(0, 1)) : codec_mode_e'(ph % 2);
			write_mode(m);
			no_gap = (ph == 0 || ph == 2);
			stim_q.delete();
			while (stim_q.size() < ((ph == 0) ? 20 : 8)) begin
				if (m == MODE_ENC) push_enc_msg(); else push_dec_msg();
			end
			if (ph == 0) begin
				hold_req = 1'b1;
				wait (hold_on);
			end
			foreach (stim_q[i]) begin
				if (ph == 1 && i == stim_q.size() / 2) wait_idle();
				send_item(stim_q[i]);
			end
		end

		wait_idle();
		if (exp_q.size() != 0) $display("%0d expected results never arrived", exp_q.size());
		$display("sent %0d encode and %0d decode transfers across %0d mode writes",
			n_enc, n_dec, n_cfg);
		$display("checked %0d results (%0d error results), %0d mismatches",
			n_res, n_err_res, bad_cnt);
		if (bad_cnt == 0 && exp_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### base32_codec.f
design/b32_pkg.sv
design/b32_front.sv
design/b32_queue.sv
design/b32_back.sv
design/base32_codec.sv
design/b32_checker.sv
tb/sv/tb_base32_codec.sv
